// ===== design/cte_pkg.sv =====
package cte_pkg;

  localparam int LINES     = 1024;
  localparam int LINE_W    = $clog2(LINES);
  localparam int WAY_W     = LINE_W + 1;
  localparam int CNT_W     = 32;
  localparam int TAG_W     = 32;
  localparam int ADDR_W    = 32;
  localparam int OFF_W     = 5;
  localparam int SETB_W    = 4;
  localparam int LFSR_W    = 16;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
  localparam logic [SETB_W-1:0] MAX_SB    = SETB_W'(LINE_W);

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_MISS_AL  = 2'd1;
  localparam logic [1:0] ST_MISS_NAL = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_SETB   = 3'd1;
  localparam logic [2:0] REG_WAYS   = 3'd2;
  localparam logic [2:0] REG_RMODE  = 3'd3;
  localparam logic [2:0] REG_WBACK  = 3'd4;
  localparam logic [2:0] REG_WALLOC = 3'd5;
  localparam logic [2:0] REG_LIMIT  = 3'd6;

  typedef enum logic [1:0] {
    RM_FIFO = 2'd0,
    RM_LFU  = 2'd1,
    RM_LRU  = 2'd2,
    RM_RAND = 2'd3
  } rmode_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset_bits;
    logic [SETB_W-1:0] set_bits;
    logic [WAY_W-1:0]  ways;
    rmode_t            replace_mode;
    logic              write_back_mode;
    logic              write_allocate_mode;
    logic [ADDR_W-1:0] address_limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } line_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    lfsr_next = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction

endpackage

// ===== design/cte_regs.sv =====
module cte_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cte_pkg::PADDR_W-1:0]  paddr,
  input  logic [cte_pkg::PDATA_W-1:0]  pwdata,
  output logic [cte_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cte_pkg::cfg_t                cfg
);

  cte_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits         <= cte_pkg::OFF_W'(2);
      cfg_r.set_bits            <= '0;
      cfg_r.ways                <= cte_pkg::WAY_W'(1);
      cfg_r.replace_mode        <= cte_pkg::RM_FIFO;
      cfg_r.write_back_mode     <= 1'b0;
      cfg_r.write_allocate_mode <= 1'b1;
      cfg_r.address_limit       <= '1;
    end else if (wr_en) begin
      case (idx)
        cte_pkg::REG_OFFSET: cfg_r.offset_bits <= pwdata[cte_pkg::OFF_W-1:0];
        cte_pkg::REG_SETB:   cfg_r.set_bits    <= pwdata[cte_pkg::SETB_W-1:0];
        cte_pkg::REG_WAYS:   cfg_r.ways        <= pwdata[cte_pkg::WAY_W-1:0];
        cte_pkg::REG_RMODE:  cfg_r.replace_mode <= cte_pkg::rmode_t'(pwdata[1:0]);
        cte_pkg::REG_WBACK:  cfg_r.write_back_mode <= pwdata[0];
        cte_pkg::REG_WALLOC: cfg_r.write_allocate_mode <= pwdata[0];
        cte_pkg::REG_LIMIT:  cfg_r.address_limit <= pwdata[cte_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cte_pkg::REG_OFFSET: prdata = cte_pkg::PDATA_W'(cfg_r.offset_bits);
      cte_pkg::REG_SETB:   prdata = cte_pkg::PDATA_W'(cfg_r.set_bits);
      cte_pkg::REG_WAYS:   prdata = cte_pkg::PDATA_W'(cfg_r.ways);
      cte_pkg::REG_RMODE:  prdata = cte_pkg::PDATA_W'(cfg_r.replace_mode);
      cte_pkg::REG_WBACK:  prdata = cte_pkg::PDATA_W'(cfg_r.write_back_mode);
      cte_pkg::REG_WALLOC: prdata = cte_pkg::PDATA_W'(cfg_r.write_allocate_mode);
      cte_pkg::REG_LIMIT:  prdata = cte_pkg::PDATA_W'(cfg_r.address_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== design/cte_store.sv =====
module cte_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [cte_pkg::LINE_W-1:0]  waddr,
  input  cte_pkg::line_t              wdata,
  input  logic [cte_pkg::LINE_W-1:0]  raddr,
  output cte_pkg::line_t              rdata
);

  cte_pkg::line_t mem [cte_pkg::LINES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cte_mod.sv =====
// restoring remainder, one quotient bit per cycle
module cte_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cte_pkg::LFSR_W-1:0]  dividend,
  input  logic [cte_pkg::WAY_W-1:0]   divisor,
  output logic                        done,
  output logic [cte_pkg::LINE_W-1:0]  rem
);

  localparam int STEP_W = $clog2(cte_pkg::LFSR_W);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [cte_pkg::LFSR_W-1:0]  dvd_r, dvd_nxt;
  logic [cte_pkg::LINE_W-1:0]  rem_r, rem_nxt;
  logic [cte_pkg::WAY_W-1:0]   part;

  assign part = {rem_r, dvd_r[cte_pkg::LFSR_W-1]};
  assign done = done_r;
  assign rem  = rem_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      dvd_nxt  = dvd_r << 1;
      rem_nxt  = (part >= divisor) ? cte_pkg::LINE_W'(part - divisor)
                                   : cte_pkg::LINE_W'(part);
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(cte_pkg::LFSR_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== design/cache_tag_replacement_engine.sv =====
// Channel  | Ports                                       | Transfer
// ---------+---------------------------------------------+--------------------------
// access   | start, busy, in_op, in_address              | start && !busy
// result   | out_valid, out_status, out_line_index,      | one cycle on out_valid
//          | out_victim_written_back, out_wrote_through  |
// config   | psel, penable, pwrite, paddr, pwdata,       | psel && penable && pwrite
//          | prdata, pready                              |
//
// Sequence: a valid access passes check, a set walk that reads its ways one at
//   a time through the single tag store read port, decide, fetch and write, with
//   the bit-serial LFSR modulo after decide on a random-mode miss; a write miss
//   without allocation ends at decide. An out-of-range address ends at check.
// Reset: synchronous, rst_n low. After reset a clearing pass writes all 1024
//   lines, one per cycle, with busy high.
// Stalls: the receiver cannot hold results off; the next access is taken in the
//   cycle the result is shown.
module cache_tag_replacement_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [31:0]                  in_address,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [9:0]                   out_line_index,
  output logic                         out_victim_written_back,
  output logic                         out_wrote_through,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cte_pkg::PADDR_W-1:0]  paddr,
  input  logic [cte_pkg::PDATA_W-1:0]  pwdata,
  output logic [cte_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int LW = cte_pkg::LINE_W;
  localparam int WW = cte_pkg::WAY_W;
  localparam int CW = cte_pkg::CNT_W;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_MOD    = 8'b0010_0000,
    S_FETCH  = 8'b0100_0000,
    S_WRITE  = 8'b1000_0000
  } state_t;

  cte_pkg::cfg_t  cfg;
  cte_pkg::line_t rd_data, wr_data;
  logic           mem_we;
  logic [LW-1:0]  mem_waddr, mem_raddr;
  logic           mod_start, mod_done;
  logic [LW-1:0]  mod_rem;

  state_t                        state_r, state_nxt;
  logic [LW-1:0]                 clr_r, clr_nxt;
  logic                          op_r, op_nxt;
  logic [cte_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]                 acc_r, acc_nxt;
  logic [cte_pkg::LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [cte_pkg::TAG_W-1:0]     tag_r, tag_nxt;
  logic [LW-1:0]                 first_r, first_nxt;
  logic [WW-1:0]                 nways_r, nways_nxt;
  logic [LW-1:0]                 way_r, way_nxt;
  logic                          iss_done_r, iss_done_nxt;
  logic                          chk_v_r, chk_v_nxt;
  logic [LW-1:0]                 chk_way_r, chk_way_nxt;
  logic                          chk_last_r, chk_last_nxt;
  logic                          hit_r, hit_nxt;
  logic [LW-1:0]                 hit_way_r, hit_way_nxt;
  logic [CW-1:0]                 max_r, max_nxt;
  logic [CW-1:0]                 min_r, min_nxt;
  logic [LW-1:0]                 min_way_r, min_way_nxt;
  logic [LW-1:0]                 target_r, target_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [LW-1:0]                 out_line_r, out_line_nxt;
  logic                          out_wb_r, out_wb_nxt;
  logic                          out_wt_r, out_wt_nxt;

  // geometry, taken apart in the check state
  logic [cte_pkg::SETB_W-1:0]    sb;
  logic [WW-1:0]                 nsets, maxways, geo_ways;
  logic [cte_pkg::ADDR_W-1:0]    block;
  logic [LW-1:0]                 setno;
  logic [LW+WW-1:0]              prod;
  logic [cte_pkg::LFSR_W-1:0]    lfsr_step;
  cte_pkg::line_t                upd;

  cte_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cte_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_data),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  cte_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (lfsr_step),
    .divisor  (nways_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_line_index          = out_line_r;
  assign out_victim_written_back = out_wb_r;
  assign out_wrote_through       = out_wt_r;

  assign sb       = (cfg.set_bits > cte_pkg::MAX_SB) ? cte_pkg::MAX_SB : cfg.set_bits;
  assign nsets    = WW'(1) << sb;
  assign maxways  = WW'(cte_pkg::LINES) >> sb;
  assign geo_ways = (cfg.ways == '0) ? WW'(1) :
                    ((cfg.ways > maxways) ? maxways : cfg.ways);
  assign block    = addr_r >> cfg.offset_bits;
  assign setno    = block[LW-1:0] & LW'(nsets - WW'(1));
  assign prod     = (LW+WW)'(setno) * (LW+WW)'(geo_ways);
  assign lfsr_step = cte_pkg::lfsr_next(lfsr_r);

  // write port: clearing sweep or the single update per access
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : target_r;
  assign wr_data   = (state_r == S_CLEAR) ? '0 : upd;
  assign mem_raddr = (state_r == S_SCAN) ? LW'(first_r + way_r) : target_r;
  assign mod_start = (state_r == S_DECIDE) && !hit_r &&
                     !(op_r && !cfg.write_allocate_mode) &&
                     (cfg.replace_mode == cte_pkg::RM_RAND);

  // new line contents for the hit or refill
  always_comb begin
    upd = rd_data;
    if (hit_r) begin
      if (cfg.replace_mode == cte_pkg::RM_LFU) begin
        upd.cnt = cte_pkg::sat_inc(rd_data.cnt);
      end else if (cfg.replace_mode == cte_pkg::RM_LRU) begin
        upd.cnt = cte_pkg::sat_inc(max_r);
      end
      if (op_r && cfg.write_back_mode) begin
        upd.dirty = 1'b1;
      end
    end else begin
      upd.valid = 1'b1;
      upd.dirty = 1'b0;
      upd.tag   = tag_r;
      case (cfg.replace_mode)
        cte_pkg::RM_FIFO: upd.cnt = acc_r;
        cte_pkg::RM_LRU:  upd.cnt = cte_pkg::sat_inc(max_r);
        default:          upd.cnt = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    acc_nxt        = acc_r;
    lfsr_nxt       = lfsr_r;
    tag_nxt        = tag_r;
    first_nxt      = first_r;
    nways_nxt      = nways_r;
    way_nxt        = way_r;
    iss_done_nxt   = iss_done_r;
    chk_v_nxt      = 1'b0;
    chk_way_nxt    = chk_way_r;
    chk_last_nxt   = chk_last_r;
    hit_nxt        = hit_r;
    hit_way_nxt    = hit_way_r;
    max_nxt        = max_r;
    min_nxt        = min_r;
    min_way_nxt    = min_way_r;
    target_nxt     = target_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_line_nxt   = out_line_r;
    out_wb_nxt     = out_wb_r;
    out_wt_nxt     = out_wt_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + LW'(1);
        if (clr_r == LW'(cte_pkg::LINES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          addr_nxt  = in_address;
          acc_nxt   = cte_pkg::sat_inc(acc_r);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (addr_r > cfg.address_limit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cte_pkg::ST_INVALID;
          out_line_nxt   = '0;
          out_wb_nxt     = 1'b0;
          out_wt_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          tag_nxt      = block >> sb;
          first_nxt    = prod[LW-1:0];
          nways_nxt    = geo_ways;
          way_nxt      = '0;
          iss_done_nxt = 1'b0;
          hit_nxt      = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one way per cycle, check it the cycle after
        if (!iss_done_r) begin
          chk_v_nxt    = 1'b1;
          chk_way_nxt  = way_r;
          chk_last_nxt = ((WW'(way_r) + WW'(1)) == nways_r);
          if ((WW'(way_r) + WW'(1)) == nways_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            way_nxt = way_r + LW'(1);
          end
        end
        if (chk_v_r) begin
          if (!hit_r && rd_data.valid && (rd_data.tag == tag_r)) begin
            hit_nxt     = 1'b1;
            hit_way_nxt = chk_way_r;
          end
          if ((chk_way_r == '0) || (rd_data.cnt > max_r)) begin
            max_nxt = rd_data.cnt;
          end
          if ((chk_way_r == '0) || (rd_data.cnt < min_r)) begin
            min_nxt     = rd_data.cnt;
            min_way_nxt = chk_way_r;
          end
          if (chk_last_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (hit_r) begin
          target_nxt = first_r + hit_way_r;
          state_nxt  = S_FETCH;
        end else if (op_r && !cfg.write_allocate_mode) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cte_pkg::ST_MISS_NAL;
          out_line_nxt   = '0;
          out_wb_nxt     = 1'b0;
          out_wt_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end else if (cfg.replace_mode == cte_pkg::RM_RAND) begin
          lfsr_nxt  = lfsr_step;
          state_nxt = S_MOD;
        end else begin
          target_nxt = first_r + min_way_r;
          state_nxt  = S_FETCH;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          target_nxt = first_r + mod_rem;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        out_valid_nxt = 1'b1;
        out_line_nxt  = target_r;
        if (hit_r) begin
          out_status_nxt = cte_pkg::ST_HIT;
          out_wb_nxt     = 1'b0;
          out_wt_nxt     = op_r && !cfg.write_back_mode;
        end else begin
          out_status_nxt = cte_pkg::ST_MISS_AL;
          out_wb_nxt     = cfg.write_back_mode && rd_data.valid && rd_data.dirty;
          out_wt_nxt     = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      acc_r       <= '0;
      lfsr_r      <= cte_pkg::LFSR_SEED;
      chk_v_r     <= 1'b0;
      iss_done_r  <= 1'b1;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      acc_r       <= acc_nxt;
      lfsr_r      <= lfsr_nxt;
      chk_v_r     <= chk_v_nxt;
      iss_done_r  <= iss_done_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    tag_r        <= tag_nxt;
    first_r      <= first_nxt;
    nways_r      <= nways_nxt;
    way_r        <= way_nxt;
    chk_way_r    <= chk_way_nxt;
    chk_last_r   <= chk_last_nxt;
    hit_way_r    <= hit_way_nxt;
    max_r        <= max_nxt;
    min_r        <= min_nxt;
    min_way_r    <= min_way_nxt;
    target_r     <= target_nxt;
    out_status_r <= out_status_nxt;
    out_line_r   <= out_line_nxt;
    out_wb_r     <= out_wb_nxt;
    out_wt_r     <= out_wt_nxt;
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> out_valid)
    else $error("line update without result");

  a_way_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (WW'(chk_way_r) < nways_r))
    else $error("scan beyond set");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is abandoned. The slowest
  // access walks 1024 ways plus the random-mode modulo, and the clearing pass
  // after reset writes all 1024 lines. Sender gaps stay short.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 64;

  typedef struct {
    logic [1:0] status;
    logic [9:0] line;
    logic       wb;
    logic       wt;
  } access_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_op = 1'b0;
  logic [cte_pkg::ADDR_W-1:0]   in_address = '0;
  logic                         out_valid;
  logic [1:0]                   out_status;
  logic [9:0]                   out_line_index;
  logic                         out_victim_written_back;
  logic                         out_wrote_through;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [cte_pkg::PADDR_W-1:0]  paddr = '0;
  logic [cte_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [cte_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  cache_tag_replacement_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_line_index(out_line_index),
    .out_victim_written_back(out_victim_written_back),
    .out_wrote_through(out_wrote_through),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the tag store and its settings
  cte_pkg::cfg_t              shadow_cfg;
  logic                       tag_valid [cte_pkg::LINES];
  logic                       tag_dirty [cte_pkg::LINES];
  logic [cte_pkg::TAG_W-1:0]  tag_value [cte_pkg::LINES];
  logic [cte_pkg::CNT_W-1:0]  tag_count [cte_pkg::LINES];
  logic [cte_pkg::CNT_W-1:0]  access_total;
  logic [cte_pkg::LFSR_W-1:0] victim_lfsr;

  access_result_t pending_results[$];
  int unsigned    error_count = 0;
  int unsigned    items_sent = 0;
  int unsigned    status_tally [4] = '{0, 0, 0, 0};
  int unsigned    writebacks_seen = 0;
  int unsigned    idle_cycles = 0;

  function automatic logic [cte_pkg::CNT_W-1:0] count_up(
      input logic [cte_pkg::CNT_W-1:0] v);
    return (v == {cte_pkg::CNT_W{1'b1}}) ? v : v + cte_pkg::CNT_W'(1);
  endfunction

  // Works out the result of one accepted access and updates the shadow store.
  function automatic access_result_t predict_access(input logic op,
                                                    input logic [cte_pkg::ADDR_W-1:0] addr);
    access_result_t               r;
    int unsigned                  sb, nsets, nways, first, i;
    logic [cte_pkg::LINE_W-1:0]   pick, ln;
    logic [cte_pkg::ADDR_W-1:0]   block, tag_bits;
    logic [cte_pkg::CNT_W-1:0]    top, best, fresh;
    bit                           hit;
    r = '{cte_pkg::ST_INVALID, 10'd0, 1'b0, 1'b0};
    access_total = count_up(access_total);
    if (addr > shadow_cfg.address_limit) return r;

    sb = 32'(shadow_cfg.set_bits);
    while (sb > 0 && (1 << sb) > cte_pkg::LINES) sb--;
    nsets = 1 << sb;
    nways = 32'(shadow_cfg.ways);
    if (nways < 1) nways = 1;
    if (nways > cte_pkg::LINES / nsets) nways = cte_pkg::LINES / nsets;
    block    = addr >> shadow_cfg.offset_bits;
    tag_bits = block >> sb;
    first    = (block & (nsets - 1)) * nways;

    hit = 0;
    pick = '0;
    top = tag_count[cte_pkg::LINE_W'(first)];
    for (i = 0; i < nways; i++) begin
      ln = cte_pkg::LINE_W'(first + i);
      if (tag_count[ln] > top) top = tag_count[ln];
      if (!hit && tag_valid[ln] && tag_value[ln] == tag_bits) begin
        hit = 1;
        pick = ln;
      end
    end

    if (hit) begin
      r.status = cte_pkg::ST_HIT;
      if (shadow_cfg.replace_mode == cte_pkg::RM_LFU) tag_count[pick] = count_up(tag_count[pick]);
      else if (shadow_cfg.replace_mode == cte_pkg::RM_LRU) tag_count[pick] = count_up(top);
      if (op) begin
        if (shadow_cfg.write_back_mode) tag_dirty[pick] = 1'b1;
        else r.wt = 1'b1;
      end
    end else if (op && !shadow_cfg.write_allocate_mode) begin
      r.status = cte_pkg::ST_MISS_NAL;
      return r;
    end else begin
      r.status = cte_pkg::ST_MISS_AL;
      fresh = '0;
      if (shadow_cfg.replace_mode == cte_pkg::RM_RAND) begin
        victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ cte_pkg::LFSR_MASK)
                                     : (victim_lfsr >> 1);
        pick = cte_pkg::LINE_W'(first + 32'(victim_lfsr % nways));
      end else begin
        best = tag_count[cte_pkg::LINE_W'(first)];
        pick = cte_pkg::LINE_W'(first);
        for (i = 0; i < nways; i++) begin
          ln = cte_pkg::LINE_W'(first + i);
          if (tag_count[ln] < best) begin
            best = tag_count[ln];
            pick = ln;
          end
        end
        if (shadow_cfg.replace_mode == cte_pkg::RM_FIFO) fresh = access_total;
        else if (shadow_cfg.replace_mode == cte_pkg::RM_LRU) fresh = count_up(top);
      end
      r.wb = shadow_cfg.write_back_mode && tag_valid[pick] && tag_dirty[pick];
      tag_dirty[pick] = 1'b0;
      tag_count[pick] = fresh;
      tag_valid[pick] = 1'b1;
      tag_value[pick] = tag_bits;
    end
    r.line = pick;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker: every result strobe is matched against the oldest prediction
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_status), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_line_index !== want.line)
          report_mismatch("line_index", 32'(out_line_index), 32'(want.line));
        if (out_victim_written_back !== want.wb)
          report_mismatch("victim_written_back", 32'(out_victim_written_back),
                          32'(want.wb));
        if (out_wrote_through !== want.wt)
          report_mismatch("wrote_through", 32'(out_wrote_through), 32'(want.wt));
      end
    end
  end

  // Watchdog: counts cycles with neither an access transfer nor a result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One access transfer; the sender idles at random for idle_pct percent of cycles
  task automatic send_access(input logic op, input logic [cte_pkg::ADDR_W-1:0] addr,
                             input int unsigned idle_pct);
    access_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_op = op;
    in_address = addr;
    do @(posedge clk); while (busy);
    r = predict_access(op, addr);
    pending_results.push_back(r);
    items_sent++;
    status_tally[r.status]++;
    if (r.wb) writebacks_seen++;
  endtask

  // Stops sending and waits for every predicted result to come back
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx,
                           input logic [cte_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = cte_pkg::PADDR_W'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      cte_pkg::REG_OFFSET: shadow_cfg.offset_bits = value[cte_pkg::OFF_W-1:0];
      cte_pkg::REG_SETB:   shadow_cfg.set_bits = value[cte_pkg::SETB_W-1:0];
      cte_pkg::REG_WAYS:   shadow_cfg.ways = value[cte_pkg::WAY_W-1:0];
      cte_pkg::REG_RMODE:  shadow_cfg.replace_mode = cte_pkg::rmode_t'(value[1:0]);
      cte_pkg::REG_WBACK:  shadow_cfg.write_back_mode = value[0];
      cte_pkg::REG_WALLOC: shadow_cfg.write_allocate_mode = value[0];
      cte_pkg::REG_LIMIT:  shadow_cfg.address_limit = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_all(input int unsigned offs, input int unsigned sb,
                         input int unsigned nw, input cte_pkg::rmode_t mode,
                         input bit wback, input bit walloc,
                         input logic [cte_pkg::ADDR_W-1:0] limit);
    drain();
    write_reg(cte_pkg::REG_OFFSET, offs);
    write_reg(cte_pkg::REG_SETB, sb);
    write_reg(cte_pkg::REG_WAYS, nw);
    write_reg(cte_pkg::REG_RMODE, 32'(mode));
    write_reg(cte_pkg::REG_WBACK, 32'(wback));
    write_reg(cte_pkg::REG_WALLOC, 32'(walloc));
    write_reg(cte_pkg::REG_LIMIT, limit);
  endtask

  // Directed: write-through and write-back, no-write-allocate, the address
  // limit, each victim policy, and geometry beyond the store's size.
  task automatic test_directed;
    send_access(1'b0, 32'h0, 0);
    send_access(1'b0, 32'h3, 0);              // same block: hit
    send_access(1'b1, 32'h0, 0);              // write hit, written through
    send_access(1'b0, 32'hFFFF_FFFF, 0);      // top address displaces line
    set_all(2, 0, 1, cte_pkg::RM_FIFO, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_access(1'b1, 32'hFFFF_FFFC, 0);      // write hit marks dirty
    send_access(1'b0, 32'h0, 0);              // dirty victim written back
    set_all(2, 0, 1, cte_pkg::RM_FIFO, 1'b1, 1'b0, 32'h0000_1000);
    send_access(1'b1, 32'h100, 0);            // write miss, no allocation
    send_access(1'b0, 32'h1001, 0);           // above the limit
    send_access(1'b0, 32'h1000, 0);           // exactly at the limit
    send_access(1'b1, 32'hFFFF_FFFF, 0);
    set_all(0, 1, 4, cte_pkg::RM_LRU, 1'b0, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) send_access(1'b0, 32'(i * 2), 0);
    send_access(1'b0, 32'h0, 0);
    set_all(4, 1, 4, cte_pkg::RM_LFU, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h10, 0);
    send_access(1'b0, 32'h10, 0);
    set_all(3, 2, 2, cte_pkg::RM_RAND, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h100, 0);
    send_access(1'b0, 32'h200, 0);
    set_all(31, 15, 2047, cte_pkg::RM_FIFO, 1'b0, 1'b1, 32'hFFFF_FFFF);  // clamped geometry
    send_access(1'b0, 32'h8000_0000, 0);
    send_access(1'b0, 32'h7FFF_FFFF, 0);
    set_all(16, 10, 0, cte_pkg::RM_LRU, 1'b0, 1'b1, 32'hFFFF_FFFF);      // zero ways acts as one
    send_access(1'b1, 32'hABCD_0000, 0);
    send_access(1'b0, 32'hABCD_FFFF, 0);
  endtask

  // Random phases: mostly accesses to a small pool of blocks so that sets fill,
  // hit and evict; the rest are fully random addresses.
  task automatic test_random_phases;
    logic [cte_pkg::ADDR_W-1:0] pool [16];
    logic [cte_pkg::ADDR_W-1:0] addr, lim;
    int unsigned offs, sb, nw, count, idle;
    for (int ph = 0; ph < 12; ph++) begin
      offs = $urandom_range(0, 8);
      sb = $urandom_range(0, 4);
      nw = $urandom_range(1, 8);
      count = 74;
      if (ph == 0) begin sb = 0; nw = 1024; count = 12; end       // fully associative, widest
      else if (ph == 1) begin sb = 10; nw = 1; end                // direct mapped, most sets
      else if (ph == 2) offs = $urandom_range(17, 31);
      lim = ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF;
      set_all(offs, sb, nw, cte_pkg::rmode_t'($urandom_range(3)), 1'($urandom_range(1)),
              1'($urandom_range(1)), lim);
      for (int i = 0; i < 16; i++) pool[4'(i)] = $urandom;
      idle = (ph % 4 == 1) ? 69 : (ph % 4 == 3) ? 21 : 0;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(39) == 0) drain();
        if ($urandom_range(4) == 0) addr = $urandom;
        else addr = pool[4'($urandom_range(nw < 4 ? 15 : 7))] ^ 32'($urandom_range(3));
        send_access(1'($urandom_range(1)), addr, idle);
      end
    end
  endtask

  initial begin
    shadow_cfg = '{offset_bits: 5'd2, set_bits: '0, ways: 11'd1,
                   replace_mode: cte_pkg::RM_FIFO,
                   write_back_mode: 1'b0, write_allocate_mode: 1'b1,
                   address_limit: 32'hFFFF_FFFF};
    for (int i = 0; i < cte_pkg::LINES; i++) begin
      tag_valid[cte_pkg::LINE_W'(i)] = 1'b0;
      tag_dirty[cte_pkg::LINE_W'(i)] = 1'b0;
      tag_value[cte_pkg::LINE_W'(i)] = '0;
      tag_count[cte_pkg::LINE_W'(i)] = '0;
    end
    access_total = '0;
    victim_lfsr = cte_pkg::LFSR_SEED;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);   // clearing pass

    test_directed();
    test_random_phases();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d accesses: %0d hits, %0d allocating misses, %0d unallocated, %0d invalid",
             items_sent, status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    $display("%0d dirty write-backs over all four victim policies", writebacks_seen);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
